// File: sv/cassette_fsk_frame_transmitter_defines.svh
// Assertion macros for the cassette FSK frame transmitter.
// Used by the top level; the bodies refer to clk and rst_n of the including module.
`ifndef CASSETTE_FSK_FRAME_TRANSMITTER_DEFINES_SVH
`define CASSETTE_FSK_FRAME_TRANSMITTER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CFSK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsk assertion failed");
// next-cycle implication
`define CFSK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfsk assertion failed");
`else
`define CFSK_ASSERT_IMP(lbl, ante, cons)
`define CFSK_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/cfsk_pkg.sv
// Shared types and constants of the cassette FSK frame transmitter.
// No dependencies; used by every module of the block but cfsk_ram.
`default_nettype none
package cfsk_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int CMD_FIFO_DEPTH  = 2;

    localparam int FRAME_W        = 5;
    localparam int SHIFT_W        = 10;
    localparam int TONE_W         = 16;
    localparam int TICK_W         = 5;
    localparam int FBIT_W         = 4;
    localparam int TICKS_PER_BIT  = 16;
    localparam int BITS_PER_FRAME = 10;

    localparam logic [FRAME_W-1:0] SYNC_FRAME = 5'h1f;
    localparam logic [SHIFT_W-1:0] STOP_BITS  = 10'h3e0;

    localparam logic [TONE_W-1:0] TONE_ZERO_RST = 16'hcccc;
    localparam logic [TONE_W-1:0] TONE_ONE_RST  = 16'haaaa;

    // input op codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SYNC  = 3'd2;
    localparam logic [OP_W-1:0] OP_START = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN   = 3'd4;

    // classified command kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] CMD_NOP   = 3'd0;
    localparam logic [KIND_W-1:0] CMD_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] CMD_BYTE  = 3'd2;
    localparam logic [KIND_W-1:0] CMD_SYNC  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_START = 3'd4;
    localparam logic [KIND_W-1:0] CMD_RUN   = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_ONE  = 2'd1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame_hi;   // first frame to queue (sync frame too)
        logic [FRAME_W-1:0] frame_lo;   // second frame of a byte push
    } cmd_t;

    typedef struct packed {
        logic line_level;
        logic accepted;
        logic stopped;
        logic underrun;
    } result_t;

endpackage
`default_nettype wire

// File: sv/cfsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cfsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/cfsk_front.sv
// Front end: takes input transactions and classifies them into commands.
// Depends on cfsk_pkg.
`default_nettype none
module cfsk_front (
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [cfsk_pkg::OP_W-1:0]  op,
    input  wire logic [7:0]                 data_byte,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output cfsk_pkg::cmd_t                  cmd
);

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        cmd.frame_hi = {data_byte[7:4], 1'b0};
        cmd.frame_lo = {data_byte[3:0], 1'b0};
        unique case (op)
            cfsk_pkg::OP_TICK:  cmd.kind = cfsk_pkg::CMD_TICK;
            cfsk_pkg::OP_BYTE:  cmd.kind = cfsk_pkg::CMD_BYTE;
            cfsk_pkg::OP_SYNC:
            begin
                cmd.kind     = cfsk_pkg::CMD_SYNC;
                cmd.frame_hi = cfsk_pkg::SYNC_FRAME;
            end
            cfsk_pkg::OP_START: cmd.kind = cfsk_pkg::CMD_START;
            cfsk_pkg::OP_RUN:   cmd.kind = cfsk_pkg::CMD_RUN;
            default:            cmd.kind = cfsk_pkg::CMD_NOP;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/cfsk_cmd_fifo.sv
// Short command queue between front end and back end.
// Depends on cfsk_pkg.
`default_nettype none
module cfsk_cmd_fifo #(
    parameter int DEPTH = cfsk_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire cfsk_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output cfsk_pkg::cmd_t     pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfsk_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: sv/cfsk_back.sv
// Back end: frame queue, tick sequencer, tone registers and result register.
// Depends on cfsk_pkg and cfsk_ram.
`default_nettype none
module cfsk_back #(
    parameter int QUEUE_DEPTH = cfsk_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [cfsk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfsk_pkg::TONE_W-1:0]     cfg_data,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire cfsk_pkg::cmd_t                  cmd,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output cfsk_pkg::result_t                    out_result
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam logic [SLOT_W:0]   DEPTH_C   = (SLOT_W+1)'(QUEUE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [cfsk_pkg::TICK_W-1:0] TICK_END = cfsk_pkg::TICK_W'(cfsk_pkg::TICKS_PER_BIT);
    localparam logic [cfsk_pkg::FBIT_W-1:0] FBIT_END =
        cfsk_pkg::FBIT_W'(cfsk_pkg::BITS_PER_FRAME);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    logic [cfsk_pkg::TONE_W-1:0]  tone_zero_reg, tone_one_reg;
    logic [SLOT_W-1:0]            read_slot_reg, read_slot_next;
    logic [SLOT_W-1:0]            write_slot_reg, write_slot_next;
    logic                         stop_reg, stop_next;
    logic                         run_reg, run_next;
    logic [cfsk_pkg::TICK_W-1:0]  tick_reg, tick_next;
    logic [cfsk_pkg::FBIT_W-1:0]  fbit_reg, fbit_next;
    logic [cfsk_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [cfsk_pkg::TONE_W-1:0]  tone_reg, tone_next;
    logic                         level_reg, level_next;
    logic                         pend_reg, pend_next;
    logic [cfsk_pkg::FRAME_W-1:0] pend_frame_reg, pend_frame_next;
    logic                         byp_valid_reg;
    logic [cfsk_pkg::FRAME_W-1:0] byp_data_reg;
    logic                         out_valid_reg, out_valid_next;
    cfsk_pkg::result_t            out_result_reg, out_result_next;

    logic                         exec;
    logic                         we;
    logic [SLOT_W-1:0]            waddr, raddr;
    logic [cfsk_pkg::FRAME_W-1:0] wdata, ram_rdata, frame_rd;
    logic [SLOT_W:0]              free_cnt;
    logic [SLOT_W-1:0]            nr;
    logic                         roll, wrap, empty_hit;
    logic [cfsk_pkg::FBIT_W-1:0]  fbit_inc, fbit_new;
    logic [cfsk_pkg::TICK_W-1:0]  tick_cur;
    logic [cfsk_pkg::SHIFT_W-1:0] shift_new;
    logic [cfsk_pkg::TONE_W-1:0]  tone_new;
    logic                         acc, urun;

    // a command runs when the low-frame write of a byte push is done
    // and the result register has room
    assign exec      = cmd_valid && !pend_reg && (!out_valid_reg || out_ready);
    assign cmd_ready = exec;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // RAM reads ahead at the slot after the next read pointer; bypass same-edge writes
    assign raddr    = next_slot(read_slot_next);
    assign frame_rd = byp_valid_reg ? byp_data_reg : ram_rdata;

    cfsk_ram #(
        .WIDTH (cfsk_pkg::FRAME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign free_cnt = (read_slot_reg >= write_slot_reg)
                    ? ({1'b0, read_slot_reg} - {1'b0, write_slot_reg})
                    : ({1'b0, read_slot_reg} + DEPTH_C - {1'b0, write_slot_reg});

    // tick datapath
    assign nr        = next_slot(read_slot_reg);
    assign roll      = tick_reg == TICK_END;
    assign fbit_inc  = fbit_reg + 1'b1;
    assign wrap      = roll && (fbit_inc >= FBIT_END);
    assign empty_hit = wrap && (nr == write_slot_reg);
    assign shift_new = wrap ? (cfsk_pkg::STOP_BITS | {5'b0, frame_rd}) : shift_reg;
    assign fbit_new  = wrap ? '0 : (roll ? fbit_inc : fbit_reg);
    assign tone_new  = roll ? (shift_new[fbit_new] ? tone_one_reg : tone_zero_reg) : tone_reg;
    assign tick_cur  = roll ? '0 : tick_reg;

    always_comb
    begin
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        stop_next       = stop_reg;
        run_next        = run_reg;
        tick_next       = tick_reg;
        fbit_next       = fbit_reg;
        shift_next      = shift_reg;
        tone_next       = tone_reg;
        level_next      = level_reg;
        pend_next       = pend_reg;
        pend_frame_next = pend_frame_reg;
        we              = 1'b0;
        waddr           = write_slot_reg;
        wdata           = cmd.frame_hi;
        acc             = 1'b0;
        urun            = 1'b0;

        if (pend_reg)
        begin
            we              = 1'b1;
            wdata           = pend_frame_reg;
            write_slot_next = next_slot(write_slot_reg);
            pend_next       = 1'b0;
        end
        else if (exec)
        begin
            unique case (cmd.kind)
                cfsk_pkg::CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        if (empty_hit)
                        begin
                            stop_next = 1'b1;
                            run_next  = 1'b0;
                            fbit_next = '0;
                            tick_next = TICK_END;
                            urun      = 1'b1;
                        end
                        else
                        begin
                            read_slot_next = wrap ? nr : read_slot_reg;
                            shift_next     = shift_new;
                            fbit_next      = fbit_new;
                            tone_next      = tone_new;
                            level_next     = tone_new[tick_cur[3:0]];
                            tick_next      = tick_cur + 1'b1;
                        end
                    end
                end
                cfsk_pkg::CMD_BYTE:
                begin
                    if (!stop_reg && free_cnt >= (SLOT_W+1)'(2))
                    begin
                        we              = 1'b1;
                        write_slot_next = next_slot(write_slot_reg);
                        pend_next       = 1'b1;
                        pend_frame_next = cmd.frame_lo;
                        acc             = 1'b1;
                    end
                end
                cfsk_pkg::CMD_SYNC:
                begin
                    if (!stop_reg && free_cnt >= (SLOT_W+1)'(1))
                    begin
                        we              = 1'b1;
                        write_slot_next = next_slot(write_slot_reg);
                        acc             = 1'b1;
                    end
                end
                cfsk_pkg::CMD_START:
                begin
                    stop_next       = 1'b0;
                    run_next        = 1'b0;
                    read_slot_next  = LAST_SLOT;
                    write_slot_next = '0;
                    tick_next       = '0;
                    fbit_next       = '0;
                end
                cfsk_pkg::CMD_RUN:
                begin
                    if (!stop_reg)
                    begin
                        run_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_valid_next  = out_valid_reg && !out_ready;
        out_result_next = out_result_reg;
        if (exec)
        begin
            out_valid_next             = 1'b1;
            out_result_next.line_level = level_next;
            out_result_next.accepted   = acc;
            out_result_next.stopped    = stop_next;
            out_result_next.underrun   = urun;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_zero_reg  <= cfsk_pkg::TONE_ZERO_RST;
            tone_one_reg   <= cfsk_pkg::TONE_ONE_RST;
            read_slot_reg  <= LAST_SLOT;
            write_slot_reg <= '0;
            stop_reg       <= 1'b0;
            run_reg        <= 1'b0;
            tick_reg       <= '0;
            fbit_reg       <= '0;
            shift_reg      <= '0;
            tone_reg       <= '0;
            level_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            byp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == cfsk_pkg::CFG_TONE_ZERO)
            begin
                tone_zero_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == cfsk_pkg::CFG_TONE_ONE)
            begin
                tone_one_reg <= cfg_data;
            end
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            stop_reg       <= stop_next;
            run_reg        <= run_next;
            tick_reg       <= tick_next;
            fbit_reg       <= fbit_next;
            shift_reg      <= shift_next;
            tone_reg       <= tone_next;
            level_reg      <= level_next;
            pend_reg       <= pend_next;
            byp_valid_reg  <= we && (waddr == raddr);
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_frame_reg <= pend_frame_next;
        byp_data_reg   <= wdata;
        out_result_reg <= out_result_next;
    end

endmodule
`default_nettype wire

// File: sv/cassette_fsk_frame_transmitter.sv
// Top level of the cassette FSK frame transmitter.
// Depends on cfsk_pkg, cfsk_front, cfsk_cmd_fifo, cfsk_back and the defines header.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tuser: op; tdata: data_byte
//  m_axis    | out       | m_axis_tvalid/tready    | tdata: level, accepted, stopped, underrun
//  cfg       | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data (16-bit tone word)
//
// One transaction per cycle in and out unless the receiver stalls or a byte push
// holds the back end, whose two frames go one after the other through the single
// write port of the frame RAM. A transaction passes the command queue, then the
// result register, before its result is valid. rst_n clears all control state at
// once; the frame store has no clearing pass. Either side may stall: the
// two-entry command queue and the result register decouple front, back and output.
`default_nettype none
`include "cassette_fsk_frame_transmitter_defines.svh"
module cassette_fsk_frame_transmitter #(
    parameter int QUEUE_DEPTH = cfsk_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [cfsk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] data_byte
    input  wire logic [cfsk_pkg::OP_W-1:0]            s_axis_tuser,  // [2:0] op
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] line_level, [1] accepted, [2] stopped, [3] underrun, [7:4] zero
    output logic      [cfsk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cfsk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cfsk_pkg::TONE_W-1:0]          cfg_data
);

    logic              front_valid, front_ready;
    cfsk_pkg::cmd_t    front_cmd;
    logic              cmd_valid, cmd_ready;
    cfsk_pkg::cmd_t    cmd;
    cfsk_pkg::result_t result;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    cfsk_front u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .op        (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    cfsk_cmd_fifo #(
        .DEPTH (cfsk_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    cfsk_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {4'b0, result.underrun, result.stopped, result.accepted,
                           result.line_level};

    // an underrun result always reports the stop it caused
    `CFSK_ASSERT_IMP(a_underrun_stops, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2])
    // a stopped transmitter never takes a push
    `CFSK_ASSERT_IMP(a_no_push_stopped, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[2])
    // a full command queue still has a command for the back end next cycle
    `CFSK_ASSERT_NXT(a_full_queue_drains, !s_axis_tready, cmd_valid)

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the cassette FSK frame transmitter.
// Needs cfsk_pkg and the RTL top level; a built-in predictor supplies the expected results.
`timescale 1ns / 1ps
module testbench;

    // ---------------------------------------------------------------------
    // Constants
    // ---------------------------------------------------------------------
    localparam int QD            = cfsk_pkg::QUEUE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 4;     // settle margin after the last result
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 80;    // long sink stall, fills the block
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction at all

    // op codes the block ignores, and register indexes it does not decode
    localparam logic [cfsk_pkg::OP_W-1:0] OP_UNUSED_FIRST = cfsk_pkg::OP_RUN + 3'd1;
    localparam logic [cfsk_pkg::OP_W-1:0] OP_UNUSED_LAST  = '1;
    localparam logic [cfsk_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST =
        cfsk_pkg::CFG_TONE_ONE + 2'd1;
    localparam logic [cfsk_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LAST  = '1;

    // ---------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ---------------------------------------------------------------------
    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [cfsk_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic [cfsk_pkg::OP_W-1:0]        s_axis_tuser  = '0;   // [2:0] op
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [0] level [1] accepted [2] stopped [3] underrun
    logic [cfsk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [cfsk_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [cfsk_pkg::TONE_W-1:0]      cfg_data      = '0;

    always #5 clk = ~clk;

    cassette_fsk_frame_transmitter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Run control and statistics
    // ---------------------------------------------------------------------
    bit src_gaps = 1'b1;   // sender inserts random idle bursts
    bit sink_gaps = 1'b1;  // receiver inserts random stall bursts
    bit hold_req = 1'b0;   // ask the receiver for one long stall

    int n_errors   = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_refused  = 0;
    int n_underrun = 0;
    int n_tone_sets = 0;

    cfsk_pkg::result_t tone_results_due[$];  // expected results, oldest first

    // ---------------------------------------------------------------------
    // Predictor state: a private copy of the transmitter
    // ---------------------------------------------------------------------
    logic [cfsk_pkg::TONE_W-1:0]  m_tone0 = cfsk_pkg::TONE_ZERO_RST;
    logic [cfsk_pkg::TONE_W-1:0]  m_tone1 = cfsk_pkg::TONE_ONE_RST;
    logic [cfsk_pkg::FRAME_W-1:0] m_frames [QD];
    int                           m_head  = QD - 1;     // slot of the frame now playing
    int                           m_tail  = 0;          // next slot to fill
    bit                           m_stopped = 1'b0;
    bit                           m_running = 1'b0;
    logic [cfsk_pkg::TICK_W-1:0]  m_tick  = '0;         // 0..16
    logic [cfsk_pkg::FBIT_W-1:0]  m_bitno = '0;         // 0..9
    logic [cfsk_pkg::SHIFT_W-1:0] m_shift = '0;
    logic [cfsk_pkg::TONE_W-1:0]  m_tone  = '0;
    logic                         m_level = 1'b0;

    function automatic void queue_frame(input logic [cfsk_pkg::FRAME_W-1:0] frame);
        m_frames[m_tail] = frame;
        m_tail = (m_tail + 1) % QD;
    endfunction

    // Advance the private copy by one accepted transaction, return what the block should report.
    function automatic cfsk_pkg::result_t predict_tone_step(
        input logic [cfsk_pkg::OP_W-1:0] op,
        input logic [7:0] data);
        cfsk_pkg::result_t r;
        int                free;
        int                nxt;
        r    = '0;
        free = (m_head + QD - m_tail) % QD;
        case (op)
            cfsk_pkg::OP_TICK:
                if (m_running)
                begin
                    // end of a bit period: pick the next frame bit, maybe the next frame
                    if (m_tick >= cfsk_pkg::TICKS_PER_BIT)
                    begin
                        m_tick = '0;
                        m_bitno++;
                        if (m_bitno >= cfsk_pkg::BITS_PER_FRAME)
                        begin
                            m_bitno = '0;
                            nxt = (m_head + 1) % QD;
                            if (nxt == m_tail)
                            begin
                                // underrun: stop, hold the level, park the tick counter
                                m_stopped  = 1'b1;
                                m_running  = 1'b0;
                                m_tick     = cfsk_pkg::TICK_W'(cfsk_pkg::TICKS_PER_BIT);
                                r.underrun = 1'b1;
                            end
                            else
                            begin
                                m_head  = nxt;
                                m_shift = cfsk_pkg::STOP_BITS
                                        | cfsk_pkg::SHIFT_W'(m_frames[nxt]);
                            end
                        end
                        if (!r.underrun)
                            m_tone = m_shift[m_bitno] ? m_tone1 : m_tone0;
                    end
                    if (!r.underrun)
                    begin
                        m_level = m_tone[m_tick[3:0]];
                        m_tick++;
                    end
                end
            cfsk_pkg::OP_BYTE:
                if (!m_stopped && free >= 2)
                begin
                    queue_frame({data[7:4], 1'b0});   // high nibble first, start bit in bit 0
                    queue_frame({data[3:0], 1'b0});
                    r.accepted = 1'b1;
                end
            cfsk_pkg::OP_SYNC:
                if (!m_stopped && free >= 1)
                begin
                    queue_frame(cfsk_pkg::SYNC_FRAME);
                    r.accepted = 1'b1;
                end
            cfsk_pkg::OP_START:
            begin
                // tone word, shift register and level are kept
                m_stopped = 1'b0;
                m_running = 1'b0;
                m_head    = QD - 1;
                m_tail    = 0;
                m_tick    = '0;
                m_bitno   = '0;
            end
            cfsk_pkg::OP_RUN:
                if (!m_stopped)
                    m_running = 1'b1;
            default: ;
        endcase
        if ((op == cfsk_pkg::OP_BYTE || op == cfsk_pkg::OP_SYNC) && !r.accepted)
            n_refused++;
        if (r.underrun)
            n_underrun++;
        r.line_level = m_level;
        r.stopped    = m_stopped;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: one input transaction, then maybe an idle burst
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [cfsk_pkg::OP_W-1:0] op, input logic [7:0] data);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!s_axis_tready);
        tone_results_due.push_back(predict_tone_step(op, data));
        n_items++;
        if (src_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, let every expected result come back, then settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tone_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; only ever issued with the block drained.
    task automatic set_tone(input logic [cfsk_pkg::CFG_IDX_W-1:0] idx,
                            input logic [cfsk_pkg::TONE_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cfsk_pkg::CFG_TONE_ZERO)
            m_tone0 = value;
        else if (idx == cfsk_pkg::CFG_TONE_ONE)
            m_tone1 = value;
        n_tone_sets++;
    endtask

    task automatic push_random();
        if ($urandom_range(0, 4) < 3)
            send_item(cfsk_pkg::OP_BYTE, 8'($urandom));
        else
            send_item(cfsk_pkg::OP_SYNC, 8'($urandom));
    endtask

    // Any op code, any byte.
    task automatic send_noise(input int count);
        repeat (count)
            send_item(cfsk_pkg::OP_W'($urandom_range(0, OP_UNUSED_LAST)), 8'($urandom));
    endtask

    // Mostly well-formed sessions: start, a few pushes, run, a long tick train with
    // rare pushes (so the queue runs dry now and then). The rest is noise.
    task automatic play_random(input int budget);
        int sent;
        int k;
        int n;
        int pick;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, 3);
                n = $urandom_range(60, 480);
                send_item(cfsk_pkg::OP_START, 8'($urandom));
                repeat (k) push_random();
                send_item(cfsk_pkg::OP_RUN, 8'($urandom));
                repeat (n)
                begin
                    pick = $urandom_range(0, 199);
                    if (pick < 2)
                        push_random();
                    else if (pick < 3)
                        send_item(cfsk_pkg::OP_RUN, 8'($urandom));
                    else if (pick < 4)
                        send_item(cfsk_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST,
                                                                 OP_UNUSED_LAST)),
                                  8'($urandom));
                    else
                        send_item(cfsk_pkg::OP_TICK, 8'($urandom));
                end
                sent += n + k + 2;
            end
            else
            begin
                n = $urandom_range(4, 16);
                send_noise(n);
                sent += n;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request
    // ---------------------------------------------------------------------
    initial
    begin : sink_ready
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checking: every output transaction against the oldest expectation
    // ---------------------------------------------------------------------
    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : score_results
        cfsk_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tone_results_due.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = tone_results_due.pop_front();
                check_field("line_level", want.line_level, m_axis_tdata[0]);
                check_field("accepted",   want.accepted,   m_axis_tdata[1]);
                check_field("stopped",    want.stopped,    m_axis_tdata[2]);
                check_field("underrun",   want.underrun,   m_axis_tdata[3]);
                n_checked++;
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Field extremes and every op, with reset tones; unmapped register writes.
    task automatic test_directed_ops();
        send_item(cfsk_pkg::OP_TICK, 8'h00);            // not running: level held
        send_item(OP_UNUSED_FIRST, 8'hff);
        send_item(OP_UNUSED_LAST, 8'h00);
        send_item(cfsk_pkg::OP_RUN, 8'h00);
        repeat (3) send_item(cfsk_pkg::OP_TICK, 8'hff); // held (cleared) tone word plays first
        send_item(cfsk_pkg::OP_START, 8'hff);
        send_item(cfsk_pkg::OP_BYTE, 8'h00);
        send_item(cfsk_pkg::OP_BYTE, 8'hff);
        send_item(cfsk_pkg::OP_SYNC, 8'h00);
        send_item(cfsk_pkg::OP_BYTE, 8'h5a);
        send_item(cfsk_pkg::OP_RUN, 8'hff);
        repeat (3) send_item(cfsk_pkg::OP_TICK, 8'h00);
        send_item(cfsk_pkg::OP_START, 8'h00);
        // writes outside the register map must leave both tones alone
        set_tone(CFG_UNMAPPED_FIRST, 16'h0000);
        set_tone(CFG_UNMAPPED_LAST, 16'hffff);
    endtask

    // Fill the frame queue: a byte needs two free slots, a sync one.
    task automatic test_queue_full();
        send_item(cfsk_pkg::OP_START, 8'h00);
        repeat (QD / 2) send_item(cfsk_pkg::OP_BYTE, 8'($urandom));  // last one refused
        send_item(cfsk_pkg::OP_SYNC, 8'h00);                          // takes the final slot
        send_item(cfsk_pkg::OP_SYNC, 8'h00);                          // refused
        send_item(cfsk_pkg::OP_BYTE, 8'($urandom));                   // refused
        send_item(cfsk_pkg::OP_START, 8'h00);
        repeat (QD / 2) send_item(cfsk_pkg::OP_BYTE, 8'($urandom));
        send_item(cfsk_pkg::OP_SYNC, 8'hff);
        send_item(cfsk_pkg::OP_START, 8'h00);
    endtask

    // Run dry from an empty queue, then everything that a stop must refuse or ignore.
    task automatic test_underrun_and_stop();
        send_item(cfsk_pkg::OP_START, 8'h00);
        send_item(cfsk_pkg::OP_RUN, 8'h00);
        repeat (cfsk_pkg::TICKS_PER_BIT * cfsk_pkg::BITS_PER_FRAME + 8)
            send_item(cfsk_pkg::OP_TICK, 8'($urandom));
        send_item(cfsk_pkg::OP_BYTE, 8'ha5);   // refused while stopped
        send_item(cfsk_pkg::OP_SYNC, 8'h00);   // refused while stopped
        send_item(cfsk_pkg::OP_RUN, 8'h00);    // ignored while stopped
        repeat (2) send_item(cfsk_pkg::OP_TICK, 8'h00);
        send_item(cfsk_pkg::OP_START, 8'h00);  // only start clears the stop
        send_item(cfsk_pkg::OP_SYNC, 8'h00);
        send_item(cfsk_pkg::OP_RUN, 8'h00);
        repeat (2) send_item(cfsk_pkg::OP_TICK, 8'h00);
    endtask

    // Random sessions under reset tones, both extremes and random tone words.
    task automatic test_tone_settings();
        play_random(250);
        set_tone(cfsk_pkg::CFG_TONE_ZERO, 16'h0000);
        set_tone(cfsk_pkg::CFG_TONE_ONE,  16'hffff);
        play_random(250);
        set_tone(cfsk_pkg::CFG_TONE_ZERO, 16'hffff);
        set_tone(cfsk_pkg::CFG_TONE_ONE,  16'h0000);
        play_random(250);
        repeat (2)
        begin
            set_tone(cfsk_pkg::CFG_TONE_ZERO, cfsk_pkg::TONE_W'($urandom));
            set_tone(cfsk_pkg::CFG_TONE_ONE,  cfsk_pkg::TONE_W'($urandom));
            play_random(250);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        src_gaps = 1'b0;
        send_item(cfsk_pkg::OP_START, 8'h00);
        send_item(cfsk_pkg::OP_BYTE, 8'($urandom));
        send_item(cfsk_pkg::OP_RUN, 8'h00);
        hold_req = 1'b1;
        repeat (40) send_item(cfsk_pkg::OP_TICK, 8'($urandom));
        wait (!hold_req);
        src_gaps = 1'b1;
    endtask

    // Unstructured op mix.
    task automatic test_noise();
        send_noise(120);
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_steady_stream();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        play_random(250);
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_queue_full();
        test_underrun_and_stop();
        test_tone_settings();
        test_backpressure();
        test_noise();
        test_steady_stream();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tone_results_due.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, tone_results_due.size());
        end

        $display("Sent %0d transactions (%0d pushes refused, %0d underruns), %0d tone writes.",
                 n_items, n_refused, n_underrun, n_tone_sets);
        $display("Compared %0d results field by field, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
